// File: hdl/irpd_pkg.sv
// ----------------------------------------------------------------------------
// irpd_pkg
// Shared types, codes and timing constants of the IR pulse-distance decoder.
// ----------------------------------------------------------------------------
package irpd_pkg;

  localparam int TIME_W     = 15;  // nominal timing register width
  localparam int DUR_W      = 16;  // measured duration width
  localparam int TOL_W      = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int DATA_FIELDS = 6;

  localparam logic [TOL_W-1:0] WIDE_TOL   = 9'd400;
  localparam logic [TOL_W-1:0] NARROW_TOL = 9'd200;

  localparam logic [7:0] BYTE_ALL_ONES = 8'hFF;

  // register reset values
  localparam logic [TIME_W-1:0] HEADER_MARK_RST  = 15'd6100;
  localparam logic [TIME_W-1:0] HEADER_SPACE_RST = 15'd7400;
  localparam logic [TIME_W-1:0] BIT_MARK_RST     = 15'd540;
  localparam logic [TIME_W-1:0] ZERO_SPACE_RST   = 15'd540;
  localparam logic [TIME_W-1:0] ONE_SPACE_RST    = 15'd1620;
  localparam logic [TIME_W-1:0] FOOTER_MARK_RST  = 15'd540;
  localparam logic [TIME_W-1:0] FOOTER_SPACE_RST = 15'd7400;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER_MARK  = 3'd0,
    REG_HEADER_SPACE = 3'd1,
    REG_BIT_MARK     = 3'd2,
    REG_ZERO_SPACE   = 3'd3,
    REG_ONE_SPACE    = 3'd4,
    REG_FOOTER_MARK  = 3'd5,
    REG_FOOTER_SPACE = 3'd6
  } reg_index_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_LENGTH  = 2'd1,
    STATUS_INVALID = 2'd2
  } status_t;

  // outcome of one mark/space bit pair
  typedef struct packed {
    logic bit_val;
    logic fault;
  } pair_class_t;

  // |value - nominal| <= tol
  function automatic logic near_to(logic [DUR_W-1:0] value,
                                   logic [TIME_W-1:0] nominal,
                                   logic [TOL_W-1:0] tol);
    logic [DUR_W-1:0] nom_ext;
    logic [DUR_W-1:0] diff;
    nom_ext = {1'b0, nominal};
    diff = (value >= nom_ext) ? (value - nom_ext) : (nom_ext - value);
    return diff <= {{(DUR_W-TOL_W){1'b0}}, tol};
  endfunction

endpackage

// File: hdl/irpd_pulse_if.sv
// ----------------------------------------------------------------------------
// irpd_pulse_if
// Duration channel: one measured mark or space per beat.
// ----------------------------------------------------------------------------
interface irpd_pulse_if;
  logic        valid;
  logic        ready;
  logic [15:0] duration;
  logic        frame_last;

  modport source (output valid, output duration, output frame_last, input ready);
  modport sink   (input valid, input duration, input frame_last, output ready);
endinterface

// File: hdl/irpd_frame_if.sv
// ----------------------------------------------------------------------------
// irpd_frame_if
// Frame result channel: status and six data bytes per beat.
// ----------------------------------------------------------------------------
interface irpd_frame_if import irpd_pkg::*; ();
  logic       valid;
  logic       ready;
  status_t    status;
  logic [7:0] data_byte0;
  logic [7:0] data_byte1;
  logic [7:0] data_byte2;
  logic [7:0] data_byte3;
  logic [7:0] data_byte4;
  logic [7:0] data_byte5;

  modport source (output valid, output status, output data_byte0, output data_byte1,
                  output data_byte2, output data_byte3, output data_byte4,
                  output data_byte5, input ready);
  modport sink   (input valid, input status, input data_byte0, input data_byte1,
                  input data_byte2, input data_byte3, input data_byte4,
                  input data_byte5, output ready);
endinterface

// File: hdl/irpd_pair_decode.sv
// ----------------------------------------------------------------------------
// irpd_pair_decode
// Classifies one mark/space pair as a zero bit, a one bit or a fault.
// ----------------------------------------------------------------------------
module irpd_pair_decode import irpd_pkg::*; (
  input  logic [DUR_W-1:0]  mark,
  input  logic [DUR_W-1:0]  space,
  input  logic [TIME_W-1:0] bit_mark_time,
  input  logic [TIME_W-1:0] zero_space_time,
  input  logic [TIME_W-1:0] one_space_time,
  output pair_class_t       pair_class
);

  logic mark_ok;
  logic zero_ok;
  logic one_ok;

  assign mark_ok = near_to(mark, bit_mark_time, NARROW_TOL);
  assign zero_ok = near_to(space, zero_space_time, NARROW_TOL);
  assign one_ok  = near_to(space, one_space_time, WIDE_TOL);

  // zero window wins where both fit
  assign pair_class.bit_val = mark_ok && !zero_ok && one_ok;
  assign pair_class.fault   = !(mark_ok && (zero_ok || one_ok));

endmodule

// File: hdl/ir_pulse_distance_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// ir_pulse_distance_frame_decoder_unit
// IR pulse-distance frame decoder with complemented byte pairs.
// ----------------------------------------------------------------------------
// Takes one measured duration per beat: header mark and space, PACKET_BYTES*8
// mark/space bit pairs (LSB first), then footer mark, footer space and footer
// mark (197 beats at the default of 12 bytes). Every even byte must be the
// complement of the following odd byte; the odd bytes are the data. On the
// beat flagged frame_last one result beat leaves with a status (ok, wrong
// length, invalid timing/complement; length wins) and up to six data bytes,
// all zero unless the status is ok. A duration is accepted every clock unless
// stalled: the whole per-beat check is one pass of compare logic between the
// duration input and the state/result registers, so the result appears in the
// cycle after the last duration. The result sits in an output register; input
// is stalled only while that register is full and its beat is not taken. The
// user must write timing registers via cfg_write/cfg_index/cfg_data only while
// the unit is idle (not enforced); indexes past the register list are ignored.
// ----------------------------------------------------------------------------
module ir_pulse_distance_frame_decoder_unit import irpd_pkg::*; #(
  parameter int PACKET_BYTES = 12   // 2..12
) (
  input  logic                 clk,
  input  logic                 rst,
  irpd_pulse_if.sink           pulse,
  irpd_frame_if.source         frame,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]    cfg_data
);

  // frame layout, in beats
  localparam int BIT_PAIRS   = PACKET_BYTES * 8;
  localparam int FRAME_ITEMS = 2 + 2 * BIT_PAIRS + 3;
  localparam int NUM_DATA    = PACKET_BYTES / 2;

  localparam logic [7:0] BITS_END     = 8'(2 + 2 * BIT_PAIRS);
  localparam logic [7:0] FRAME_LEN    = 8'(FRAME_ITEMS);
  localparam logic [7:0] FOOT_MARK_A  = 8'(FRAME_ITEMS - 3);
  localparam logic [7:0] FOOT_SPACE   = 8'(FRAME_ITEMS - 2);
  localparam logic [7:0] FOOT_MARK_B  = 8'(FRAME_ITEMS - 1);
  localparam logic [7:0] COUNT_MAX    = 8'hFF;

  // timing registers
  logic [TIME_W-1:0] header_mark_time;
  logic [TIME_W-1:0] header_space_time;
  logic [TIME_W-1:0] bit_mark_time;
  logic [TIME_W-1:0] zero_space_time;
  logic [TIME_W-1:0] one_space_time;
  logic [TIME_W-1:0] footer_mark_time;
  logic [TIME_W-1:0] footer_space_time;

  // frame state
  logic [7:0]       item_count, item_count_next;
  logic [DUR_W-1:0] held_mark, held_mark_next;
  logic [7:0]       bit_shifter, bit_shifter_next;
  logic [7:0]       complement_byte, complement_byte_next;
  logic             invalid_seen, invalid_seen_next;
  logic [7:0]       data_store [DATA_FIELDS];
  logic             store_we;
  logic [2:0]       store_slot;

  // result register
  logic       out_valid;
  status_t    out_status, status_next;
  logic [7:0] out_data [DATA_FIELDS];
  logic [7:0] data_next [DATA_FIELDS];

  logic        accept;
  logic [7:0]  pos;         // position within the bit-pair section
  logic        item_fault;
  pair_class_t pair_class;

  assign pulse.ready = !out_valid || frame.ready;
  assign accept      = pulse.valid && pulse.ready;

  // -- configuration ---------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      header_mark_time  <= HEADER_MARK_RST;
      header_space_time <= HEADER_SPACE_RST;
      bit_mark_time     <= BIT_MARK_RST;
      zero_space_time   <= ZERO_SPACE_RST;
      one_space_time    <= ONE_SPACE_RST;
      footer_mark_time  <= FOOTER_MARK_RST;
      footer_space_time <= FOOTER_SPACE_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_HEADER_MARK:  header_mark_time  <= cfg_data;
        REG_HEADER_SPACE: header_space_time <= cfg_data;
        REG_BIT_MARK:     bit_mark_time     <= cfg_data;
        REG_ZERO_SPACE:   zero_space_time   <= cfg_data;
        REG_ONE_SPACE:    one_space_time    <= cfg_data;
        REG_FOOTER_MARK:  footer_mark_time  <= cfg_data;
        REG_FOOTER_SPACE: footer_space_time <= cfg_data;
        default: ;
      endcase
    end
  end

  // -- bit pair classification (current duration is the space) --------------
  irpd_pair_decode u_pair_decode (
    .mark            (held_mark),
    .space           (pulse.duration),
    .bit_mark_time   (bit_mark_time),
    .zero_space_time (zero_space_time),
    .one_space_time  (one_space_time),
    .pair_class      (pair_class)
  );

  // -- per-beat step ---------------------------------------------------------
  // pos = item_count - 2: bit 0 selects mark/space, [3:1] bit in byte,
  // [4] even/odd byte, [7:5] data slot.
  assign pos = item_count - 8'd2;

  always_comb begin
    item_count_next      = (item_count != COUNT_MAX) ? item_count + 8'd1 : item_count;
    held_mark_next       = held_mark;
    bit_shifter_next     = bit_shifter;
    complement_byte_next = complement_byte;
    store_we             = 1'b0;
    store_slot           = pos[7:5];
    item_fault           = 1'b0;

    if (item_count == 8'd0) begin
      item_fault = !near_to(pulse.duration, header_mark_time, WIDE_TOL);
    end else if (item_count == 8'd1) begin
      item_fault = !near_to(pulse.duration, header_space_time, WIDE_TOL);
    end else if (item_count < BITS_END) begin
      if (!pos[0]) begin
        held_mark_next = pulse.duration;
      end else begin
        item_fault       = pair_class.fault;
        bit_shifter_next = {pair_class.bit_val, bit_shifter[7:1]};
        if (pos[3:1] == 3'd7) begin
          if (!pos[4]) begin
            complement_byte_next = bit_shifter_next;
          end else begin
            if ((complement_byte ^ bit_shifter_next) != BYTE_ALL_ONES) begin
              item_fault = 1'b1;
            end
            store_we = 1'b1;
          end
        end
      end
    end else if (item_count == FOOT_MARK_A) begin
      item_fault = !near_to(pulse.duration, footer_mark_time, NARROW_TOL);
    end else if (item_count == FOOT_SPACE) begin
      item_fault = !near_to(pulse.duration, footer_space_time, WIDE_TOL);
    end else if (item_count == FOOT_MARK_B) begin
      item_fault = !near_to(pulse.duration, footer_mark_time, NARROW_TOL);
    end

    invalid_seen_next = invalid_seen || item_fault;

    // result of a frame ending on this beat; length error wins
    if (item_count_next != FRAME_LEN) begin
      status_next = STATUS_LENGTH;
    end else if (invalid_seen_next) begin
      status_next = STATUS_INVALID;
    end else begin
      status_next = STATUS_OK;
    end

    // an ok frame never writes the store on its final beat
    for (int k = 0; k < DATA_FIELDS; k++) begin
      data_next[k] = (status_next == STATUS_OK && k < NUM_DATA) ? data_store[k] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_count      <= '0;
      held_mark       <= '0;
      bit_shifter     <= '0;
      complement_byte <= '0;
      invalid_seen    <= 1'b0;
    end else if (accept) begin
      held_mark       <= held_mark_next;
      complement_byte <= complement_byte_next;
      if (pulse.frame_last) begin
        item_count   <= '0;
        bit_shifter  <= '0;
        invalid_seen <= 1'b0;
      end else begin
        item_count   <= item_count_next;
        bit_shifter  <= bit_shifter_next;
        invalid_seen <= invalid_seen_next;
      end
    end
  end

  // data bytes, written when an odd byte completes
  always_ff @(posedge clk) begin
    if (accept && store_we && (32'(store_slot) < DATA_FIELDS)) begin
      data_store[store_slot] <= bit_shifter_next;
    end
  end

  // -- result register -------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && pulse.frame_last) begin
      out_valid <= 1'b1;
    end else if (frame.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && pulse.frame_last) begin
      out_status <= status_next;
      out_data   <= data_next;
    end
  end

  assign frame.valid      = out_valid;
  assign frame.status     = out_status;
  assign frame.data_byte0 = out_data[0];
  assign frame.data_byte1 = out_data[1];
  assign frame.data_byte2 = out_data[2];
  assign frame.data_byte3 = out_data[3];
  assign frame.data_byte4 = out_data[4];
  assign frame.data_byte5 = out_data[5];

endmodule
